[design/srwc_pkg.sv]
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared types and constants of the selective repeat window controller.
// ----------------------------------------------------------------------------
package srwc_pkg;

  localparam int SEQ_W        = 5;
  localparam int SLOT_W       = 4;
  localparam int LEN_W        = 9;
  localparam int TICK_W       = 16;
  localparam int SEQ_SPACE    = 32;
  localparam int WINDOW_SLOTS = 16;
  localparam int MAX_PAYLOAD  = 256;
  localparam int CNT_W        = $clog2(SEQ_SPACE + 1);

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ACT_NEW_PACKET = 2'd0,
    ACT_PHY_READY  = 2'd1,
    ACT_FRAME      = 2'd2,
    ACT_TIMEOUT    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CMD_SEND_DATA   = 3'd0,
    CMD_SEND_ACK    = 3'd1,
    CMD_START_TIMER = 3'd2,
    CMD_STOP_TIMER  = 3'd3,
    CMD_DELIVER     = 3'd4,
    CMD_STATUS      = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [1:0] action;
    logic       frame_is_ack;
    seq_t       seq_num;
    logic       crc_failed;
    len_t       length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    seq_t       seq_out;
    slot_t      slot;
    len_t       byte_count;
    tick_t      timer_ticks;
    logic       network_enable;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic emit;
    cmd_e emit_cmd;
    logic phy_set;
    logic phy_clr;
    logic next_inc;
    logic send_wr;
    logic send_rd;
    logic ack_mark;
    logic slide_step;
    logic cache_mark;
    logic cnt_clr;
    logic recv_rd;
    logic deliver_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    out_free;
    action_e act;
    logic    is_ack;
    logic    bad;
    logic    net_en;
    logic    send_in_win;
    logic    recv_in_win;
    logic    cached_seq;
    logic    acked_base;
    logic    slide_last;
    logic    cnt_last;
    logic    deliver_ok;
    logic    cached_rb;
  } dp_status_t;

  // b lies on the ring segment from a to c
  function automatic logic in_ring(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b <= c)) || ((c <= a) && (a <= b)) || ((b <= c) && (c <= a));
  endfunction

endpackage

[design/srwc_ram.sv]
// ----------------------------------------------------------------------------
// srwc_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module srwc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/srwc_dpath.sv]
// ----------------------------------------------------------------------------
// srwc_dpath
// Window state, length stores, event latch and result register.
// ----------------------------------------------------------------------------
module srwc_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srwc_pkg::in_item_t   in_data_i,
  input  logic                 cfg_valid_i,
  input  srwc_pkg::tick_t      cfg_data_i,
  input  srwc_pkg::dp_cmd_t    cmd_i,
  output srwc_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srwc_pkg::out_item_t  out_data_o
);
  import srwc_pkg::*;

  seq_t                 base_q, base_d;
  seq_t                 next_q, next_d;
  seq_t                 rb_q, rb_d;
  logic                 phy_q, phy_d;
  logic [SEQ_SPACE-1:0] acked_q, acked_d;
  logic [SEQ_SPACE-1:0] cached_q, cached_d;
  tick_t                timeout_q, timeout_d;
  cnt_t                 cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  action_e act_q;
  logic    ack_q;
  seq_t    seq_q;
  logic    bad_q;
  len_t    len_q, len_d;

  len_t send_rdata;
  len_t recv_rdata;
  logic out_free;
  logic net_en;
  seq_t emit_seq;

  // saturate payload length
  assign len_d = (in_data_i.length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                          : in_data_i.length;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_e'(in_data_i.action);
      ack_q <= in_data_i.frame_is_ack;
      seq_q <= in_data_i.seq_num;
      bad_q <= in_data_i.crc_failed;
      len_q <= len_d;
    end
  end

  srwc_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_SLOTS)) u_send_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.send_wr),
    .waddr_i (next_q[SLOT_W-1:0]),
    .wdata_i (len_q),
    .re_i    (cmd_i.send_rd),
    .raddr_i (seq_q[SLOT_W-1:0]),
    .rdata_o (send_rdata)
  );

  srwc_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_SLOTS)) u_recv_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cache_mark),
    .waddr_i (seq_q[SLOT_W-1:0]),
    .wdata_i (len_q),
    .re_i    (cmd_i.recv_rd),
    .raddr_i (rb_q[SLOT_W-1:0]),
    .rdata_o (recv_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign net_en   = phy_q && in_ring(base_q, next_q, base_q + SEQ_W'(WINDOW_SLOTS - 1));

  always_comb begin
    status_o.out_free    = out_free;
    status_o.act         = act_q;
    status_o.is_ack      = ack_q;
    status_o.bad         = bad_q;
    status_o.net_en      = net_en;
    status_o.send_in_win = in_ring(base_q, seq_q, base_q + SEQ_W'(WINDOW_SLOTS - 1));
    status_o.recv_in_win = in_ring(rb_q, seq_q, rb_q + SEQ_W'(WINDOW_SLOTS - 1));
    status_o.cached_seq  = cached_q[seq_q];
    status_o.acked_base  = acked_q[base_q];
    status_o.slide_last  = ((base_q + SEQ_W'(1)) == next_q);
    status_o.cnt_last    = (cnt_q == CNT_W'(SEQ_SPACE - 1));
    status_o.deliver_ok  = (cnt_q < CNT_W'(WINDOW_SLOTS));
    status_o.cached_rb   = cached_q[rb_q];
  end

  always_comb begin
    base_d    = base_q;
    next_d    = next_q;
    rb_d      = rb_q;
    phy_d     = phy_q;
    acked_d   = acked_q;
    cached_d  = cached_q;
    timeout_d = timeout_q;
    cnt_d     = cnt_q;

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end
    if (cmd_i.phy_set) begin
      phy_d = 1'b1;
    end
    if (cmd_i.phy_clr) begin
      phy_d = 1'b0;
    end
    if (cmd_i.next_inc) begin
      next_d = next_q + SEQ_W'(1);
    end
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end
    if (cmd_i.ack_mark) begin
      acked_d[seq_q] = 1'b1;
    end
    if (cmd_i.slide_step) begin
      acked_d[base_q] = 1'b0;
      base_d          = base_q + SEQ_W'(1);
      cnt_d           = cnt_q + CNT_W'(1);
    end
    if (cmd_i.cache_mark) begin
      cached_d[seq_q] = 1'b1;
    end
    if (cmd_i.deliver_step) begin
      cached_d[rb_q] = 1'b0;
      rb_d           = rb_q + SEQ_W'(1);
      cnt_d          = cnt_q + CNT_W'(1);
    end
  end

  // result composition
  assign emit_seq = (act_q == ACT_NEW_PACKET) ? next_q : seq_q;

  always_comb begin
    out_d = '0;
    out_d.command = cmd_i.emit_cmd;
    case (cmd_i.emit_cmd)
      CMD_SEND_DATA: begin
        out_d.seq_out    = emit_seq;
        out_d.byte_count = (act_q == ACT_NEW_PACKET) ? len_q : send_rdata;
      end
      CMD_START_TIMER: begin
        out_d.seq_out     = emit_seq;
        out_d.timer_ticks = timeout_q;
      end
      CMD_STOP_TIMER, CMD_SEND_ACK: begin
        out_d.seq_out = seq_q;
      end
      CMD_DELIVER: begin
        out_d.seq_out    = rb_q;
        out_d.byte_count = recv_rdata;
      end
      CMD_STATUS: begin
        out_d.network_enable = net_en;
        out_d.last           = 1'b1;
      end
      default: begin
        out_d = '0;
      end
    endcase
    out_d.slot = out_d.seq_out[SLOT_W-1:0];
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      rb_q        <= '0;
      phy_q       <= 1'b0;
      acked_q     <= '0;
      cached_q    <= '0;
      timeout_q   <= TIMEOUT_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      next_q      <= next_d;
      rb_q        <= rb_d;
      phy_q       <= phy_d;
      acked_q     <= acked_d;
      cached_q    <= cached_d;
      timeout_q   <= timeout_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/srwc_ctrl.sv]
// ----------------------------------------------------------------------------
// srwc_ctrl
// Event sequencer: decodes one event and steps it through its results.
// ----------------------------------------------------------------------------
module srwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srwc_pkg::dp_status_t status_i,
  output srwc_pkg::dp_cmd_t    cmd_o
);
  import srwc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SEND   = 4'd2;
  localparam logic [3:0] S_TIMER  = 4'd3;
  localparam logic [3:0] S_STOP   = 4'd4;
  localparam logic [3:0] S_SLIDE  = 4'd5;
  localparam logic [3:0] S_ACK    = 4'd6;
  localparam logic [3:0] S_DREAD  = 4'd7;
  localparam logic [3:0] S_DELIV  = 4'd8;
  localparam logic [3:0] S_STATUS = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_cmd = CMD_STATUS;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.act)
          ACT_NEW_PACKET: begin
            if (status_i.net_en) begin
              cmd_o.send_wr = 1'b1;
              state_d       = S_SEND;
            end else begin
              state_d = S_STATUS;
            end
          end
          ACT_PHY_READY: begin
            cmd_o.phy_set = 1'b1;
            state_d       = S_STATUS;
          end
          ACT_FRAME: begin
            if (status_i.bad) begin
              state_d = S_STATUS;
            end else if (status_i.is_ack) begin
              state_d = status_i.send_in_win ? S_STOP : S_STATUS;
            end else begin
              state_d = S_ACK;
            end
          end
          ACT_TIMEOUT: begin
            cmd_o.send_rd = 1'b1;
            state_d       = S_SEND;
          end
          default: begin
            state_d = S_STATUS;
          end
        endcase
      end
      S_SEND: begin
        cmd_o.emit_cmd = CMD_SEND_DATA;
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.phy_clr = 1'b1;
          state_d       = S_TIMER;
        end
      end
      S_TIMER: begin
        cmd_o.emit_cmd = CMD_START_TIMER;
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.next_inc = (status_i.act == ACT_NEW_PACKET);
          state_d        = S_STATUS;
        end
      end
      S_STOP: begin
        cmd_o.emit_cmd = CMD_STOP_TIMER;
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.ack_mark = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          state_d        = S_SLIDE;
        end
      end
      S_SLIDE: begin
        // advance base over acked numbers, one per cycle
        if (!status_i.acked_base) begin
          state_d = S_STATUS;
        end else begin
          cmd_o.slide_step = 1'b1;
          if (status_i.slide_last || status_i.cnt_last) begin
            state_d = S_STATUS;
          end
        end
      end
      S_ACK: begin
        cmd_o.emit_cmd = CMD_SEND_ACK;
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.phy_clr = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          if (status_i.recv_in_win) begin
            cmd_o.cache_mark = !status_i.cached_seq;
            state_d          = S_DREAD;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_DREAD: begin
        if (status_i.cached_rb && status_i.deliver_ok) begin
          cmd_o.recv_rd = 1'b1;
          state_d       = S_DELIV;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_DELIV: begin
        cmd_o.emit_cmd = CMD_DELIVER;
        if (status_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.deliver_step = 1'b1;
          state_d            = S_DREAD;
        end
      end
      S_STATUS: begin
        cmd_o.emit_cmd = CMD_STATUS;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/selective_repeat_window_control.sv]
// Timing: an event is latched while the controller is idle and decoded in the next cycle;
// its results then follow in order, held while the output is stalled; status comes last.
// Flow: one event at a time; the input stalls until the status result is issued. Send
// base walk steps and delivery read steps (with the final check) put out no result.
// Reset: window pointers, flags and bitmaps clear, the timeout reads 1000; length stores
// hold no defined value until written.
// ----------------------------------------------------------------------------
// selective_repeat_window_control
// Sequence and window controller of a selective repeat link.
// ----------------------------------------------------------------------------
module selective_repeat_window_control (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srwc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srwc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  srwc_pkg::tick_t     cfg_data_i
);
  import srwc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  srwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  srwc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
